// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket receive frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 64;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 3;
    localparam int KIDX_W = 2;
    localparam int OPC_W  = 4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [CNT_W-1:0] EXT16_LAST = 3'd1;
    localparam logic [CNT_W-1:0] EXT64_LAST = 3'd7;
    localparam logic [CNT_W-1:0] KEY_LAST   = 3'd3;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_KEY     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic              item_kind;
        logic              fin_flag;
        logic [OPC_W-1:0]  frame_opcode;
        logic              mask_present;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_frame;
    } result_t;

endpackage

// ===== hdl/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// WebSocket receive deframer: header descriptor then unmasked payload bytes.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle when the output is free or being
// drained. Header bytes produce nothing until the header is complete, which
// yields one descriptor item; each payload byte then yields one item with
// the masking key applied if masked and last_of_frame set on the final byte
// (or on the descriptor of an empty frame). An item appears in the cycle after
// its byte is taken, from the single output register; in_stall is raised
// only while a result sits in that register and the downstream side stalls.
module websocket_frame_deframer_unit
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] link_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              item_kind,
    output logic              fin_flag,
    output logic [OPC_W-1:0]  frame_opcode,
    output logic              mask_present,
    output logic [LEN_W-1:0]  frame_length,
    output logic [BYTE_W-1:0] data_byte,
    output logic              last_of_frame
);

    logic    take;
    result_t res;
    result_t out_reg;

    assign in_stall = out_reg.valid & out_stall;
    assign take     = in_valid & ~in_stall;

    wsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .link_byte (link_byte),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (res.valid)
        begin
            out_reg <= res;
        end
        else if (!out_stall)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign out_valid     = out_reg.valid;
    assign item_kind     = out_reg.item_kind;
    assign fin_flag      = out_reg.fin_flag;
    assign frame_opcode  = out_reg.frame_opcode;
    assign mask_present  = out_reg.mask_present;
    assign frame_length  = out_reg.frame_length;
    assign data_byte     = out_reg.data_byte;
    assign last_of_frame = out_reg.last_of_frame;

endmodule

// ===== hdl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker; consumes one byte on each take.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] link_byte,
    output result_t           res
);

    phase_t             phase_reg, phase_next;
    logic               fin_reg, fin_next;
    logic [OPC_W-1:0]   opc_reg, opc_next;
    logic               masked_reg, masked_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [KIDX_W-1:0]  kidx_reg, kidx_next;

    logic               after_len;
    logic               hdr_done;
    logic [BYTE_W-1:0]  key_byte;

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opc_next    = opc_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        left_next   = left_reg;
        kidx_next   = kidx_reg;
        after_len   = 1'b0;
        hdr_done    = 1'b0;
        res         = '0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next   = link_byte[7];
                opc_next   = link_byte[OPC_W-1:0];
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked_next = link_byte[7];
                len_next    = {{(LEN_W-7){1'b0}}, link_byte[6:0]};
                cnt_next    = '0;
                if (link_byte[6:0] == LEN_EXT16)
                begin
                    len_next   = '0;
                    phase_next = PH_EXT16;
                end
                else if (link_byte[6:0] == LEN_EXT64)
                begin
                    len_next   = '0;
                    phase_next = PH_EXT64;
                end
                else
                begin
                    after_len = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                len_next = {len_reg[LEN_W-BYTE_W-1:0], link_byte};
                if (cnt_reg == ((phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                begin
                    after_len = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[KEY_W-BYTE_W-1:0], link_byte};
                if (cnt_reg == KEY_LAST)
                begin
                    hdr_done = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_PAYLOAD:
            begin
                kidx_next        = kidx_reg + 2'd1;
                res.valid        = 1'b1;
                res.item_kind    = KIND_PAYLOAD;
                res.fin_flag     = fin_reg;
                res.frame_opcode = opc_reg;
                res.mask_present = masked_reg;
                res.frame_length = len_reg;
                res.data_byte    = masked_reg ? (link_byte ^ key_byte) : link_byte;
                if (left_reg[LEN_W-1:1] == '0)
                begin
                    left_next         = '0;
                    res.last_of_frame = 1'b1;
                    phase_next        = PH_HDR0;
                end
                else
                begin
                    left_next = left_reg - 64'd1;
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        if (after_len)
        begin
            cnt_next = '0;
            if (masked_next)
            begin
                key_next   = '0;
                phase_next = PH_KEY;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done)
        begin
            left_next        = len_next;
            kidx_next        = '0;
            cnt_next         = '0;
            res.valid        = 1'b1;
            res.item_kind    = KIND_HEADER;
            res.fin_flag     = fin_next;
            res.frame_opcode = opc_next;
            res.mask_present = masked_next;
            res.frame_length = len_next;
            res.data_byte    = '0;
            if (len_next == '0)
            begin
                res.last_of_frame = 1'b1;
                phase_next        = PH_HDR0;
            end
            else
            begin
                phase_next = PH_PAYLOAD;
            end
        end

        if (!take)
        begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            opc_reg    <= '0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            key_reg    <= '0;
            left_reg   <= '0;
            kidx_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opc_reg    <= opc_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            left_reg   <= left_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule

// ===== tb/tb_websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit
// Self-checking bench for the WebSocket receive frame deframer.
// ----------------------------------------------------------------------------
// Raw link bytes are fed as frames: short, 16-bit and 64-bit length
// forms, masked and unmasked, empty frames and non-minimal length encodings,
// then a long run of random frames and one frame whose huge length never
// completes. A byte-level predictor tracks the header parse and the
// unmasking of each accepted byte and queues the expected descriptor or
// payload item; every item leaving the block is compared field by field.
// Both sides idle at random, apart from one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit;
    import wsd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 16;
    localparam int TOTAL_BYTES  = 650;

    typedef struct {
        logic              item_kind;
        logic              fin_flag;
        logic [OPC_W-1:0]  frame_opcode;
        logic              mask_present;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_frame;
    } deframed_item_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] link_byte = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              item_kind;
    logic              fin_flag;
    logic [OPC_W-1:0]  frame_opcode;
    logic              mask_present;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_frame;

    // predictor state
    phase_t            parse_ph;
    logic              hdr_fin;
    logic [OPC_W-1:0]  hdr_opcode;
    logic              hdr_masked;
    logic [LEN_W-1:0]  len_accum;
    logic [CNT_W-1:0]  field_cnt;
    logic [KEY_W-1:0]  xor_key;
    logic [LEN_W-1:0]  payload_left;
    logic [KIDX_W-1:0] key_pos;

    deframed_item_t    pending_items[$];
    int                mismatches  = 0;
    int                bytes_sent  = 0;
    int                cycle_count = 0;
    bit                idling_on   = 1'b1;

    websocket_frame_deframer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .link_byte     (link_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_kind     (item_kind),
        .fin_flag      (fin_flag),
        .frame_opcode  (frame_opcode),
        .mask_present  (mask_present),
        .frame_length  (frame_length),
        .data_byte     (data_byte),
        .last_of_frame (last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic queue_item(input logic kind, input logic [BYTE_W-1:0] d,
                              input logic last);
        deframed_item_t it;
        it.item_kind     = kind;
        it.fin_flag      = hdr_fin;
        it.frame_opcode  = hdr_opcode;
        it.mask_present  = hdr_masked;
        it.frame_length  = len_accum;
        it.data_byte     = d;
        it.last_of_frame = last;
        pending_items.push_back(it);
    endtask

    task automatic header_done();
        payload_left = len_accum;
        key_pos      = '0;
        field_cnt    = '0;
        if (len_accum == '0)
        begin
            queue_item(KIND_HEADER, '0, 1'b1);
            parse_ph = PH_HDR0;
        end
        else
        begin
            queue_item(KIND_HEADER, '0, 1'b0);
            parse_ph = PH_PAYLOAD;
        end
    endtask

    task automatic length_done();
        field_cnt = '0;
        if (hdr_masked)
        begin
            xor_key  = '0;
            parse_ph = PH_KEY;
        end
        else
            header_done();
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        case (parse_ph)
            PH_HDR0:
            begin
                hdr_fin    = b[7];
                hdr_opcode = b[OPC_W-1:0];
                parse_ph   = PH_HDR1;
            end
            PH_HDR1:
            begin
                hdr_masked = b[7];
                len_accum  = LEN_W'(b[6:0]);
                field_cnt  = '0;
                if (b[6:0] == LEN_EXT16)
                begin
                    len_accum = '0;
                    parse_ph  = PH_EXT16;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    len_accum = '0;
                    parse_ph  = PH_EXT64;
                end
                else
                    length_done();
            end
            PH_EXT16, PH_EXT64:
            begin
                len_accum = {len_accum[LEN_W-BYTE_W-1:0], b};
                if (field_cnt == ((parse_ph == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                    length_done();
                else
                    field_cnt = field_cnt + 3'd1;
            end
            PH_KEY:
            begin
                xor_key = {xor_key[KEY_W-BYTE_W-1:0], b};
                if (field_cnt == KEY_LAST)
                    header_done();
                else
                    field_cnt = field_cnt + 3'd1;
            end
            PH_PAYLOAD:
            begin
                d = b;
                if (hdr_masked)
                    d = d ^ xor_key[KEY_W-1-BYTE_W*key_pos -: BYTE_W];
                key_pos = key_pos + 2'd1;
                if (payload_left <= 1)
                begin
                    payload_left = '0;
                    queue_item(KIND_PAYLOAD, d, 1'b1);
                    parse_ph = PH_HDR0;
                end
                else
                begin
                    payload_left = payload_left - 64'd1;
                    queue_item(KIND_PAYLOAD, d, 1'b0);
                end
            end
            default:
                parse_ph = PH_HDR0;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [LEN_W-1:0] exp_v,
                                 input logic [LEN_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_item();
        deframed_item_t it;
        if (pending_items.size() == 0)
        begin
            $display("%0t: unexpected item, expected none, got kind %0b data %0h",
                     $time, item_kind, data_byte);
            mismatches++;
        end
        else
        begin
            it = pending_items.pop_front();
            compare_field("item_kind", LEN_W'(it.item_kind), LEN_W'(item_kind));
            compare_field("fin_flag", LEN_W'(it.fin_flag), LEN_W'(fin_flag));
            compare_field("frame_opcode", LEN_W'(it.frame_opcode), LEN_W'(frame_opcode));
            compare_field("mask_present", LEN_W'(it.mask_present), LEN_W'(mask_present));
            compare_field("frame_length", it.frame_length, frame_length);
            compare_field("data_byte", LEN_W'(it.data_byte), LEN_W'(data_byte));
            compare_field("last_of_frame", LEN_W'(it.last_of_frame),
                          LEN_W'(last_of_frame));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                deframe_byte(link_byte);
            if (out_valid && !out_stall)
                check_item();
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idling_on && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid  <= 1'b0;
            link_byte <= BYTE_W'($urandom);
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        link_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_key_and_payload(input logic masked, input int n);
        if (masked)
            repeat (4)
                send_byte(BYTE_W'($urandom));
        repeat (n)
            send_byte(BYTE_W'($urandom));
    endtask

    task automatic send_random_frame();
        int    r;
        int    n;
        logic  masked;
        r      = $urandom_range(99);
        masked = 1'($urandom_range(1));
        send_byte(BYTE_W'($urandom));
        if (r < 62)
        begin
            if (r < 8)
                n = 0;
            else if (r < 55)
                n = $urandom_range(1, 20);
            else
                n = $urandom_range(21, 125);
            send_byte({masked, 7'(n)});
        end
        else if (r < 85)
        begin
            n = (r < 80) ? $urandom_range(0, 24) : $urandom_range(0, 300);
            send_byte({masked, LEN_EXT16});
            send_byte(BYTE_W'(n >> 8));
            send_byte(BYTE_W'(n));
        end
        else
        begin
            n = $urandom_range(0, 24);
            send_byte({masked, LEN_EXT64});
            repeat (7)
                send_byte('0);
            send_byte(BYTE_W'(n));
        end
        send_key_and_payload(masked, n);
    endtask

    // empty frames, unmasked and masked, the second with every bit of the first header byte set
    task automatic test_header_only_frames();
        send_byte(8'h89);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_key_and_payload(1'b1, 0);
    endtask

    task automatic test_short_frames();
        send_byte(8'h70);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h81);
        send_byte(8'h83);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
    endtask

    // length 1 carried in the 16-bit form
    task automatic test_nonminimal_length();
        send_byte(8'h02);
        send_byte({1'b0, LEN_EXT16});
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hC3);
    endtask

    // 126 and 127 in the 16-bit field are plain lengths
    task automatic test_ext16_boundary_lengths();
        send_byte(8'h81);
        send_byte({1'b1, LEN_EXT16});
        send_byte(8'h00);
        send_byte(8'd126);
        send_key_and_payload(1'b1, 126);
        send_byte(8'h02);
        send_byte({1'b0, LEN_EXT16});
        send_byte(8'h00);
        send_byte(8'd127);
        send_key_and_payload(1'b0, 127);
    endtask

    task automatic test_back_to_back_traffic();
        int start;
        start     = bytes_sent;
        idling_on = 1'b0;
        while (bytes_sent - start < 150)
            send_random_frame();
        idling_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        while (bytes_sent < TOTAL_BYTES)
            send_random_frame();
    endtask

    // top bit of the 64-bit length set; the frame never completes
    task automatic test_huge_length();
        send_byte(8'h82);
        send_byte({1'b1, LEN_EXT64});
        send_byte(BYTE_W'($urandom) | 8'h80);
        repeat (7)
            send_byte(BYTE_W'($urandom));
        send_key_and_payload(1'b1, 12);
    endtask

    initial
    begin
        parse_ph     = PH_HDR0;
        hdr_fin      = 1'b0;
        hdr_opcode   = '0;
        hdr_masked   = 1'b0;
        len_accum    = '0;
        field_cnt    = '0;
        xor_key      = '0;
        payload_left = '0;
        key_pos      = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_only_frames();
        test_short_frames();
        test_nonminimal_length();
        test_ext16_boundary_lengths();
        test_back_to_back_traffic();
        test_random_traffic();
        test_huge_length();

        in_valid <= 1'b0;
        while (pending_items.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
